/* rtl/avps_pkg.sv */
// Shared types, constants and helpers of the aged page victim selector.
package avps_pkg;

	localparam int unsigned NUM_PAGES       = 1024;
	localparam int unsigned PAGE_W          = 10;
	localparam int unsigned PAGES_PER_TABLE = 64;
	localparam int unsigned PPT_W           = 6;
	localparam int unsigned NUM_TABLES      = NUM_PAGES / PAGES_PER_TABLE;
	localparam int unsigned TBL_W           = 4;
	localparam int unsigned MAX_AGE         = 15;
	localparam int unsigned AGE_W           = 4;
	localparam int unsigned CFG_W           = 11;
	localparam int unsigned CNT_W           = PAGE_W + 1;
	localparam int unsigned SCALE           = (MAX_AGE + 1) * (MAX_AGE + 1);
	localparam int unsigned PROD_W          = CFG_W + 2 * AGE_W + 1;

	// Request codes.
	localparam logic [1:0] REQ_WRITE_PAGE  = 2'd0;
	localparam logic [1:0] REQ_WRITE_TABLE = 2'd1;
	localparam logic [1:0] REQ_VICTIM      = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_USER_TOP    = 2'd0;
	localparam logic [1:0] CFG_CODE_END    = 2'd1;
	localparam logic [1:0] CFG_STACK_LIMIT = 2'd2;
	localparam logic [1:0] CFG_WALK        = 2'd3;

	typedef struct packed {
		logic [AGE_W-1:0] age;
		logic             multi;
		logic             pinned;
		logic             shared;
		logic             present;
	} page_entry_t;

	typedef struct packed {
		logic [CFG_W-1:0] user_top;
		logic [CFG_W-1:0] code_end;
		logic [CFG_W-1:0] stack_limit;
		logic [CFG_W-1:0] walk;
	} cfg_t;

	typedef struct packed {
		logic              found;
		logic [PAGE_W-1:0] page;
	} victim_t;

	function automatic logic [2*AGE_W-1:0] age_sq(input logic [AGE_W-1:0] a);
		return (2*AGE_W)'(a) * (2*AGE_W)'(a);
	endfunction

endpackage

/* rtl/aged_page_victim_select_core.sv */
// Aged page victim selector: page entry table, group present bits and the victim sweep.
//
// After reset the block clears the whole page entry memory and stalls its
// input meanwhile; configuration writes are taken at any time. A victim
// request walks the table from the saved cursor at one iteration per cycle,
// limited by the single read port of the entry memory: every entry read and
// every skipped group is one iteration, and the walk also has to start, drain
// the read pipeline and post the result. The input stays stalled until the
// result has moved into the output register.
module aged_page_victim_select_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [avps_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         req_type,
	input  logic [avps_pkg::PAGE_W-1:0]        page_index,
	input  logic                               page_present,
	input  logic                               page_shared,
	input  logic                               page_pinned,
	input  logic                               multi_mapped,
	input  logic [avps_pkg::AGE_W-1:0]         page_age,
	input  logic [avps_pkg::TBL_W-1:0]         table_index,
	input  logic                               table_present,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               victim_found,
	output logic [avps_pkg::PAGE_W-1:0]        victim_page
);

	avps_pkg::cfg_t                      cfg_q;
	logic [avps_pkg::NUM_TABLES-1:0]     tbl_q;
	logic                                clr_active_q;
	logic [avps_pkg::PAGE_W-1:0]         clr_addr_q;
	logic                                out_valid_q;
	logic                                victim_found_q;
	logic [avps_pkg::PAGE_W-1:0]         victim_page_q;

	logic                                accept;
	logic                                mem_we;
	logic [avps_pkg::PAGE_W-1:0]         mem_waddr;
	avps_pkg::page_entry_t               mem_wdata;
	avps_pkg::page_entry_t               new_entry;
	logic                                rd_en;
	logic [avps_pkg::PAGE_W-1:0]         rd_addr;
	avps_pkg::page_entry_t               rd_data;
	logic                                res_ready;
	logic                                res_valid;
	avps_pkg::victim_t                   res;
	logic                                busy;

	assign in_stall = clr_active_q || busy;
	assign accept   = in_valid && !in_stall;

	assign new_entry.age     = page_age;
	assign new_entry.multi   = multi_mapped;
	assign new_entry.pinned  = page_pinned;
	assign new_entry.shared  = page_shared;
	assign new_entry.present = page_present;

	// The clearing pass owns the write port until it finishes.
	assign mem_we    = clr_active_q || (accept && (req_type == avps_pkg::REQ_WRITE_PAGE));
	assign mem_waddr = clr_active_q ? clr_addr_q : page_index;
	assign mem_wdata = clr_active_q ? avps_pkg::page_entry_t'('0) : new_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == avps_pkg::PAGE_W'(avps_pkg::NUM_PAGES - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.user_top    <= avps_pkg::CFG_W'(avps_pkg::NUM_PAGES);
			cfg_q.code_end    <= '0;
			cfg_q.stack_limit <= avps_pkg::CFG_W'(avps_pkg::NUM_PAGES);
			cfg_q.walk        <= avps_pkg::CFG_W'(avps_pkg::NUM_PAGES);
		end else if (cfg_we) begin
			case (cfg_index)
				avps_pkg::CFG_USER_TOP:    cfg_q.user_top    <= cfg_data;
				avps_pkg::CFG_CODE_END:    cfg_q.code_end    <= cfg_data;
				avps_pkg::CFG_STACK_LIMIT: cfg_q.stack_limit <= cfg_data;
				avps_pkg::CFG_WALK:        cfg_q.walk        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_q <= '0;
		end else if (accept && (req_type == avps_pkg::REQ_WRITE_TABLE)) begin
			tbl_q[table_index] <= table_present;
		end
	end

	avps_page_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	avps_sweep u_sweep (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept && (req_type == avps_pkg::REQ_VICTIM)),
		.cfg         (cfg_q),
		.tbl_present (tbl_q),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.res_ready   (res_ready),
		.res_valid   (res_valid),
		.res         (res),
		.busy        (busy)
	);

	// Output register: loads when empty or when its transfer completes this cycle.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			victim_found_q <= res.found;
			victim_page_q  <= res.page;
		end
	end

	assign out_valid    = out_valid_q;
	assign victim_found = victim_found_q;
	assign victim_page  = victim_page_q;

endmodule

/* rtl/avps_page_mem.sv */
// Page entry memory: one write port and one registered read port.
module avps_page_mem (
	input  logic                           clk,
	input  logic                           we,
	input  logic [avps_pkg::PAGE_W-1:0]    waddr,
	input  avps_pkg::page_entry_t          wdata,
	input  logic                           re,
	input  logic [avps_pkg::PAGE_W-1:0]    raddr,
	output avps_pkg::page_entry_t          rdata
);

	avps_pkg::page_entry_t mem_q [avps_pkg::NUM_PAGES];
	avps_pkg::page_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/avps_sweep.sv */
// Victim sweep engine: walks the page entries from the saved cursor and keeps the youngest.
module avps_sweep (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  avps_pkg::cfg_t                      cfg,
	input  logic [avps_pkg::NUM_TABLES-1:0]     tbl_present,
	output logic                                rd_en,
	output logic [avps_pkg::PAGE_W-1:0]         rd_addr,
	input  avps_pkg::page_entry_t               rd_data,
	input  logic                                res_ready,
	output logic                                res_valid,
	output avps_pkg::victim_t                   res,
	output logic                                busy
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_HOLD = 3'b100
	} sweep_state_t;

	sweep_state_t                        state_q;
	logic [avps_pkg::CNT_W-1:0]          offset_q;
	logic [avps_pkg::CNT_W-1:0]          count_q;
	logic [avps_pkg::PAGE_W-1:0]         cursor_q;
	logic                                best_have_q;
	logic [avps_pkg::AGE_W-1:0]          best_age_q;
	logic [avps_pkg::PAGE_W-1:0]         best_page_q;
	avps_pkg::victim_t                   res_q;
	logic                                valid_s1;
	logic [avps_pkg::PAGE_W-1:0]         page_s1;
	logic [avps_pkg::CNT_W-1:0]          count_s1;

	logic                                gen_live;
	logic [avps_pkg::PAGE_W-1:0]         page;
	logic [avps_pkg::TBL_W-1:0]          grp;
	logic                                skip;
	logic [avps_pkg::CNT_W-1:0]          cnt_inc;
	logic [avps_pkg::CNT_W-1:0]          skip_step;
	logic [avps_pkg::AGE_W-1:0]          age_sat;
	logic                                eligible;
	logic                                take;
	logic                                new_have;
	logic [avps_pkg::AGE_W-1:0]          new_age;
	logic [avps_pkg::PAGE_W-1:0]         new_page;
	logic [avps_pkg::PROD_W-1:0]         lhs;
	logic [avps_pkg::PROD_W-1:0]         rhs;
	logic                                stop;
	logic                                wrap_end;
	logic                                running;

	// Address side: one iteration of the walk per cycle.
	assign running   = (state_q == S_RUN);
	assign gen_live  = running && !offset_q[avps_pkg::CNT_W-1];
	assign page      = cursor_q + offset_q[avps_pkg::PAGE_W-1:0];
	assign grp       = page[avps_pkg::PAGE_W-1:avps_pkg::PPT_W];
	assign skip      = !tbl_present[grp] || ({1'b0, page} >= cfg.user_top);
	assign cnt_inc   = count_q + 1'b1;
	assign skip_step = avps_pkg::CNT_W'(avps_pkg::PAGES_PER_TABLE)
	                 - avps_pkg::CNT_W'(page[avps_pkg::PPT_W-1:0]);
	assign rd_en     = gen_live && !skip;
	assign rd_addr   = page;

	// Evaluation side: the entry read in the previous cycle.
	assign age_sat  = (rd_data.age > avps_pkg::AGE_W'(avps_pkg::MAX_AGE))
	                ? avps_pkg::AGE_W'(avps_pkg::MAX_AGE) : rd_data.age;
	assign eligible = ({1'b0, page_s1} >= cfg.code_end) && ({1'b0, page_s1} < cfg.stack_limit)
	                && rd_data.present && !rd_data.shared && !rd_data.pinned && !rd_data.multi;
	assign take     = eligible && (!best_have_q || (age_sat < best_age_q));
	assign new_have = best_have_q || take;
	assign new_age  = take ? age_sat : best_age_q;
	assign new_page = take ? page_s1 : best_page_q;

	// Exact form of count/walk >= (age/(MAX+1))^2.
	assign lhs  = avps_pkg::PROD_W'(count_s1) * avps_pkg::PROD_W'(avps_pkg::SCALE);
	assign rhs  = avps_pkg::PROD_W'(cfg.walk) * avps_pkg::PROD_W'(avps_pkg::age_sq(new_age));
	assign stop = running && valid_s1
	            && (new_have ? (lhs >= rhs) : (count_s1 >= cfg.walk));
	assign wrap_end = running && offset_q[avps_pkg::CNT_W-1] && !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			offset_q    <= '0;
			count_q     <= '0;
			cursor_q    <= '0;
			best_have_q <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						offset_q    <= '0;
						count_q     <= '0;
						best_have_q <= 1'b0;
						valid_s1    <= 1'b0;
						state_q     <= S_RUN;
					end
				end
				S_RUN: begin
					if (stop) begin
						cursor_q <= page_s1;
						valid_s1 <= 1'b0;
						state_q  <= S_HOLD;
					end else if (wrap_end) begin
						if (!best_have_q) begin
							cursor_q <= '0;
						end
						state_q <= S_HOLD;
					end else begin
						if (valid_s1) begin
							best_have_q <= new_have;
						end
						if (gen_live) begin
							count_q  <= cnt_inc;
							offset_q <= skip ? offset_q + skip_step : offset_q + 1'b1;
						end
						valid_s1 <= gen_live && !skip;
					end
				end
				S_HOLD: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (running) begin
			if (stop) begin
				res_q.found <= new_have;
				res_q.page  <= new_have ? new_page : '0;
			end else if (wrap_end) begin
				res_q.found <= best_have_q;
				res_q.page  <= best_have_q ? best_page_q : '0;
			end else begin
				if (valid_s1) begin
					best_age_q  <= new_age;
					best_page_q <= new_page;
				end
				page_s1  <= page;
				count_s1 <= cnt_inc;
			end
		end
	end

	assign res_valid = (state_q == S_HOLD);
	assign res       = res_q;
	assign busy      = (state_q != S_IDLE);

	a_s1_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> running)
		else $error("entry in flight outside of a sweep");

	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("sweep result changed before it was taken");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= avps_pkg::CNT_W'(avps_pkg::NUM_PAGES))
		else $error("sweep visited more entries than the table holds");

	a_offset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		offset_q < avps_pkg::CNT_W'(avps_pkg::NUM_PAGES + avps_pkg::PAGES_PER_TABLE))
		else $error("sweep offset ran past the last group");

endmodule

/* tb/aged_page_victim_select_core_tb.sv */
// Self-checking testbench for the aged page victim selector core.
module aged_page_victim_select_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import avps_pkg::*;

	localparam int unsigned STALL_LIMIT = 8192;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned MAX_REPORTS = 40;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [PAGE_W-1:0] page;
		logic              present;
		logic              shared;
		logic              pinned;
		logic              multi;
		logic [AGE_W-1:0]  age;
		logic [TBL_W-1:0]  tbl;
		logic              tbl_present;
	} request_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = CFG_USER_TOP;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        req_type = REQ_WRITE_PAGE;
	logic [PAGE_W-1:0] page_index = '0;
	logic              page_present = 1'b0;
	logic              page_shared = 1'b0;
	logic              page_pinned = 1'b0;
	logic              multi_mapped = 1'b0;
	logic [AGE_W-1:0]  page_age = '0;
	logic [TBL_W-1:0]  table_index = '0;
	logic              table_present = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              victim_found;
	logic [PAGE_W-1:0] victim_page;

	// Shadow copy of the block's state.
	page_entry_t           page_table [NUM_PAGES];
	logic [NUM_TABLES-1:0] group_present;
	logic [PAGE_W-1:0]     sweep_pos;
	cfg_t                  shadow_cfg;

	victim_t     expected_victims [$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_idle_pct = 25;
	int unsigned recv_idle_pct = 51;

	aged_page_victim_select_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.page_index   (page_index),
		.page_present (page_present),
		.page_shared  (page_shared),
		.page_pinned  (page_pinned),
		.multi_mapped (multi_mapped),
		.page_age     (page_age),
		.table_index  (table_index),
		.table_present(table_present),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.victim_found (victim_found),
		.victim_page  (victim_page)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < recv_idle_pct);
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%0t ns: %s", $time, what);
		end
	endtask

	always @(posedge clk) begin : check_results
		victim_t oldest;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_victims.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: found=%0b page=%0d",
					victim_found, victim_page));
			end else begin
				oldest = expected_victims.pop_front();
				if (victim_found !== oldest.found) begin
					report_mismatch($sformatf("victim_found %0b, expected %0b",
						victim_found, oldest.found));
				end
				if (victim_page !== oldest.page) begin
					report_mismatch($sformatf("victim_page %0d, expected %0d",
						victim_page, oldest.page));
				end
			end
		end
	end

	// The run is aborted when no transfer happens on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic clear_shadow();
		foreach (page_table[i]) begin
			page_table[i] = '0;
		end
		group_present = '0;
		sweep_pos = '0;
		shadow_cfg.user_top = CFG_W'(NUM_PAGES);
		shadow_cfg.code_end = '0;
		shadow_cfg.stack_limit = CFG_W'(NUM_PAGES);
		shadow_cfg.walk = CFG_W'(NUM_PAGES);
	endtask

	// Sweeps from the saved position and moves it the way the block does.
	function automatic victim_t predict_victim();
		victim_t           res;
		int unsigned       off;
		int unsigned       pg;
		longint unsigned   visited;
		longint unsigned   lhs;
		longint unsigned   rhs;
		bit                have_best;
		int unsigned       best_age;
		logic [PAGE_W-1:0] best_page;
		page_entry_t       ent;
		bit                halt;
		off = 0;
		visited = 0;
		have_best = 1'b0;
		best_age = 0;
		best_page = '0;
		while (off < NUM_PAGES) begin
			visited++;
			pg = (int'(sweep_pos) + off) % NUM_PAGES;
			if (!group_present[pg / PAGES_PER_TABLE] || pg >= shadow_cfg.user_top) begin
				// The rest of this group is passed over in one step.
				off += PAGES_PER_TABLE - pg % PAGES_PER_TABLE;
			end else begin
				ent = page_table[pg];
				if (pg >= shadow_cfg.code_end && pg < shadow_cfg.stack_limit &&
						ent.present && !ent.shared && !ent.pinned && !ent.multi) begin
					if (!have_best || ent.age < best_age) begin
						have_best = 1'b1;
						best_age = ent.age;
						best_page = PAGE_W'(pg);
					end
				end
				if (!have_best) begin
					halt = (visited >= longint'(shadow_cfg.walk));
				end else begin
					lhs = visited * SCALE;
					rhs = longint'(shadow_cfg.walk) * best_age * best_age;
					halt = (lhs >= rhs);
				end
				if (halt) begin
					sweep_pos = PAGE_W'(pg);
					res.found = have_best;
					res.page = have_best ? best_page : '0;
					return res;
				end
				off++;
			end
		end
		// A full wrap keeps the position only when a candidate was seen.
		if (!have_best) begin
			sweep_pos = '0;
		end
		res.found = have_best;
		res.page = have_best ? best_page : '0;
		return res;
	endfunction

	task automatic commit_request(input request_t r);
		case (r.kind)
			REQ_WRITE_PAGE: begin
				page_table[r.page].present = r.present;
				page_table[r.page].shared = r.shared;
				page_table[r.page].pinned = r.pinned;
				page_table[r.page].multi = r.multi;
				page_table[r.page].age = r.age;
			end
			REQ_WRITE_TABLE: begin
				group_present[r.tbl] = r.tbl_present;
			end
			REQ_VICTIM: begin
				expected_victims.push_back(predict_victim());
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_request(input request_t r);
		bit taken;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		req_type = r.kind;
		page_index = r.page;
		page_present = r.present;
		page_shared = r.shared;
		page_pinned = r.pinned;
		multi_mapped = r.multi;
		page_age = r.age;
		table_index = r.tbl;
		table_present = r.tbl_present;
		in_valid = 1'b1;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !in_stall;
		end
		commit_request(r);
	endtask

	// Fields that a request does not use carry random values.
	function automatic request_t random_fields();
		request_t r;
		r.kind = 2'($urandom_range(3));
		r.page = PAGE_W'($urandom_range(NUM_PAGES - 1));
		r.present = 1'($urandom_range(1));
		r.shared = 1'($urandom_range(1));
		r.pinned = 1'($urandom_range(1));
		r.multi = 1'($urandom_range(1));
		r.age = AGE_W'($urandom_range(MAX_AGE));
		r.tbl = TBL_W'($urandom_range(NUM_TABLES - 1));
		r.tbl_present = 1'($urandom_range(1));
		return r;
	endfunction

	function automatic request_t page_write(input int unsigned pg, input bit present,
			input bit shared, input bit pinned, input bit multi, input int unsigned age);
		request_t r;
		r = random_fields();
		r.kind = REQ_WRITE_PAGE;
		r.page = PAGE_W'(pg);
		r.present = present;
		r.shared = shared;
		r.pinned = pinned;
		r.multi = multi;
		r.age = AGE_W'(age);
		return r;
	endfunction

	function automatic request_t table_write(input int unsigned grp, input bit present);
		request_t r;
		r = random_fields();
		r.kind = REQ_WRITE_TABLE;
		r.tbl = TBL_W'(grp);
		r.tbl_present = present;
		return r;
	endfunction

	function automatic request_t victim_request();
		request_t r;
		r = random_fields();
		r.kind = REQ_VICTIM;
		return r;
	endfunction

	// Mostly eligible page writes and present groups, so that sweeps find victims.
	function automatic request_t random_request();
		request_t    r;
		int unsigned pick;
		r = random_fields();
		pick = $urandom_range(99);
		if (pick < 50) begin
			r.kind = REQ_WRITE_PAGE;
			r.present = ($urandom_range(99) < 85);
			r.shared = ($urandom_range(99) < 8);
			r.pinned = ($urandom_range(99) < 8);
			r.multi = ($urandom_range(99) < 8);
		end else if (pick < 62) begin
			r.kind = REQ_WRITE_TABLE;
			r.tbl_present = ($urandom_range(99) < 80);
		end else if (pick < 95) begin
			r.kind = REQ_VICTIM;
		end else begin
			r.kind = REQ_UNUSED;
		end
		return r;
	endfunction

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_victims.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		case (idx)
			CFG_USER_TOP:    shadow_cfg.user_top = value;
			CFG_CODE_END:    shadow_cfg.code_end = value;
			CFG_STACK_LIMIT: shadow_cfg.stack_limit = value;
			CFG_WALK:        shadow_cfg.walk = value;
			default: begin
			end
		endcase
	endtask

	task automatic set_config(input logic [CFG_W-1:0] user_top,
			input logic [CFG_W-1:0] code_end, input logic [CFG_W-1:0] stack_limit,
			input logic [CFG_W-1:0] walk);
		wait_idle();
		write_register(CFG_USER_TOP, user_top);
		write_register(CFG_CODE_END, code_end);
		write_register(CFG_STACK_LIMIT, stack_limit);
		write_register(CFG_WALK, walk);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic test_directed();
		// Nothing present anywhere: a full wrap with no candidate.
		send_request(victim_request());
		send_request(table_write(0, 1'b1));
		send_request(victim_request());
		send_request(page_write(5, 1'b1, 1'b0, 1'b0, 1'b0, 15));
		send_request(page_write(6, 1'b1, 1'b1, 1'b0, 1'b0, 0));
		send_request(page_write(7, 1'b1, 1'b0, 1'b1, 1'b0, 0));
		send_request(page_write(8, 1'b1, 1'b0, 1'b0, 1'b1, 0));
		send_request(page_write(9, 1'b1, 1'b0, 1'b0, 1'b0, 3));
		send_request(page_write(10, 1'b0, 1'b0, 1'b0, 1'b0, 0));
		// Early stops, the second one starting from the saved position.
		send_request(victim_request());
		send_request(victim_request());
		send_request(table_write(15, 1'b1));
		send_request(page_write(NUM_PAGES - 1, 1'b1, 1'b0, 1'b0, 1'b0, 0));
		send_request(page_write(0, 1'b1, 1'b1, 1'b1, 1'b1, MAX_AGE));
		send_request(victim_request());
		send_request('{kind: REQ_UNUSED, page: '1, present: 1'b1, shared: 1'b1,
			pinned: 1'b1, multi: 1'b1, age: '1, tbl: '1, tbl_present: 1'b1});
		send_request(page_write(NUM_PAGES - 1, 1'b1, 1'b1, 1'b1, 1'b1, MAX_AGE));
		send_request(victim_request());
		send_request(table_write(0, 1'b0));
		send_request(table_write(15, 1'b0));
		send_request(victim_request());
		// Only old candidates: the sweep wraps around and keeps its position.
		send_request(page_write(9, 1'b1, 1'b0, 1'b0, 1'b0, MAX_AGE));
		send_request(table_write(0, 1'b1));
		send_request(victim_request());
		send_request(victim_request());
	endtask

	task automatic run_setting(input logic [CFG_W-1:0] user_top,
			input logic [CFG_W-1:0] code_end, input logic [CFG_W-1:0] stack_limit,
			input logic [CFG_W-1:0] walk, input int unsigned count);
		set_config(user_top, code_end, stack_limit, walk);
		for (int unsigned i = 0; i < count; i++) begin
			send_request(random_request());
		end
	endtask

	task automatic test_register_extremes();
		run_setting(11'd1024, 11'd0, 11'd1024, 11'd0, 16);
		run_setting(11'd1024, 11'd0, 11'd1024, 11'd1, 16);
		run_setting(11'd0, 11'd0, 11'd1024, 11'd1024, 16);
		run_setting(11'd1024, 11'd1024, 11'd1024, 11'd1024, 16);
		run_setting(11'd1024, 11'd0, 11'd0, 11'd1024, 16);
		run_setting(11'd512, 11'd100, 11'd900, 11'd300, 16);
		run_setting(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 16);
		run_setting(11'd1024, 11'd0, 11'd1024, 11'd1024, 16);
	endtask

	task automatic test_random_traffic(input int unsigned send_pct,
			input int unsigned recv_pct);
		logic [CFG_W-1:0] user_top;
		logic [CFG_W-1:0] code_end;
		logic [CFG_W-1:0] stack_limit;
		logic [CFG_W-1:0] walk;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int unsigned chunk = 0; chunk < 3; chunk++) begin
			user_top = ($urandom_range(99) < 60) ? 11'd1024 : CFG_W'($urandom_range(2047));
			code_end = ($urandom_range(99) < 70) ? CFG_W'($urandom_range(128))
				: CFG_W'($urandom_range(2047));
			stack_limit = ($urandom_range(99) < 70) ? CFG_W'($urandom_range(896, 1024))
				: CFG_W'($urandom_range(2047));
			walk = ($urandom_range(99) < 80) ? CFG_W'($urandom_range(1024))
				: CFG_W'($urandom_range(2047));
			run_setting(user_top, code_end, stack_limit, walk, 48);
		end
	endtask

	initial begin
		clear_shadow();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_register_extremes();
		test_random_traffic(25, 51);
		test_random_traffic(51, 25);
		test_random_traffic(0, 0);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
